[src/gamepad_sample_event_generator_defines.svh]
// Assertion macros shared by the gamepad sample event generator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef GAMEPAD_SAMPLE_EVENT_GENERATOR_DEFINES_SVH
`define GAMEPAD_SAMPLE_EVENT_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define GSEV_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gsev assertion failed");

`define GSEV_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gsev assertion failed");

`else

`define GSEV_ASSERT_IMP(label, clk, rst, ante, cons)

`define GSEV_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

[src/gsev_pkg.sv]
// Types, constants and the button remap function of the gamepad event generator.
// Depends on nothing; used by every other file of the block but the assertion macro header.
package gsev_pkg;

   localparam int BUTTON_BITS    = 16;
   localparam int INDEX_BITS     = 4;
   localparam int AXIS_BITS      = 16;
   localparam int TRIG_BITS      = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int PAD_LT_BIT     = 9;
   localparam int PAD_RT_BIT     = 11;

   localparam logic [15:0] CSR_ENABLED_RESET   = 16'd0;
   localparam logic [1:0]  CSR_PAD_RESET       = 2'd0;
   localparam logic [15:0] CSR_LEFT_DZ_RESET   = 16'd7849;
   localparam logic [15:0] CSR_RIGHT_DZ_RESET  = 16'd8689;
   localparam logic [7:0]  CSR_TRIG_THR_RESET  = 8'd30;

   localparam logic [BUTTON_BITS-1:0] NATIVE_MASK [BUTTON_BITS] = '{
      16'h0004, 16'h0001, 16'h0008, 16'h0002,
      16'h4000, 16'h8000, 16'h2000, 16'h1000,
      16'h0100, 16'h0000, 16'h0200, 16'h0000,
      16'h0040, 16'h0080, 16'h0010, 16'h0020
   };

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENABLED   = 3'd0,
      CSR_PAD       = 3'd1,
      CSR_LEFT_DZ   = 3'd2,
      CSR_RIGHT_DZ  = 3'd3,
      CSR_TRIG_THR  = 3'd4
   } csr_index_type;

   typedef enum logic {
      EV_MOVE   = 1'b0,
      EV_BUTTON = 1'b1
   } event_kind_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_AXIS = 5'b00010,
      S_TRIG = 5'b00100,
      S_MOVE = 5'b01000,
      S_SCAN = 5'b10000
   } state_type;

   typedef struct packed {
      logic                 enabled;
      logic [1:0]           pad_number;
      logic [AXIS_BITS-1:0] left_deadzone;
      logic [AXIS_BITS-1:0] right_deadzone;
      logic [TRIG_BITS-1:0] trigger_threshold;
   } cfg_type;

   typedef struct packed {
      logic                 is_axis;
      logic [AXIS_BITS-1:0] operand;
      logic [AXIS_BITS-1:0] limit;
      logic [AXIS_BITS-1:0] prior;
   } unit_in_type;

   typedef struct packed {
      logic                 pass;
      logic                 differs;
      logic [AXIS_BITS-1:0] value;
   } unit_out_type;

   typedef struct packed {
      logic                        event_kind;
      logic [1:0]                  slot;
      logic [INDEX_BITS-1:0]       button_index;
      logic                        button_down;
      logic signed [AXIS_BITS-1:0] out_left_x;
      logic signed [AXIS_BITS-1:0] out_left_y;
      logic signed [AXIS_BITS-1:0] out_right_x;
      logic signed [AXIS_BITS-1:0] out_right_y;
      logic [TRIG_BITS-1:0]        out_left_trigger;
      logic [TRIG_BITS-1:0]        out_right_trigger;
      logic                        last;
   } rsp_word_type;

   function automatic logic [BUTTON_BITS-1:0] remap_buttons(input logic [BUTTON_BITS-1:0] raw);
      logic [BUTTON_BITS-1:0] pad;
      pad = '0;
      for (int b = 0; b < BUTTON_BITS; b++) begin
         pad[b] = |(raw & NATIVE_MASK[b]);
      end
      return pad;
   endfunction

endpackage

[src/gsev_if.sv]
// Channel interfaces of the gamepad event generator: sample, event and register write.
// Depends on gsev_pkg for field widths.
interface gsev_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [gsev_pkg::BUTTON_BITS-1:0]      raw_buttons;
   logic [gsev_pkg::TRIG_BITS-1:0]        left_trigger;
   logic [gsev_pkg::TRIG_BITS-1:0]        right_trigger;
   logic signed [gsev_pkg::AXIS_BITS-1:0] left_x;
   logic signed [gsev_pkg::AXIS_BITS-1:0] left_y;
   logic signed [gsev_pkg::AXIS_BITS-1:0] right_x;
   logic signed [gsev_pkg::AXIS_BITS-1:0] right_y;
   logic                                  connected;

   modport source (output valid, raw_buttons, left_trigger, right_trigger,
                   left_x, left_y, right_x, right_y, connected, input ready);
   modport sink (input valid, raw_buttons, left_trigger, right_trigger,
                 left_x, left_y, right_x, right_y, connected, output ready);
endinterface

interface gsev_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  event_kind;
   logic [1:0]                            slot;
   logic [gsev_pkg::INDEX_BITS-1:0]       button_index;
   logic                                  button_down;
   logic signed [gsev_pkg::AXIS_BITS-1:0] out_left_x;
   logic signed [gsev_pkg::AXIS_BITS-1:0] out_left_y;
   logic signed [gsev_pkg::AXIS_BITS-1:0] out_right_x;
   logic signed [gsev_pkg::AXIS_BITS-1:0] out_right_y;
   logic [gsev_pkg::TRIG_BITS-1:0]        out_left_trigger;
   logic [gsev_pkg::TRIG_BITS-1:0]        out_right_trigger;
   logic                                  last;

   modport source (output valid, event_kind, slot, button_index, button_down,
                   out_left_x, out_left_y, out_right_x, out_right_y,
                   out_left_trigger, out_right_trigger, last, input ready);
   modport sink (input valid, event_kind, slot, button_index, button_down,
                 out_left_x, out_left_y, out_right_x, out_right_y,
                 out_left_trigger, out_right_trigger, last, output ready);
endinterface

interface gsev_csr_if;
   logic                                valid;
   logic                                ready;
   logic [gsev_pkg::CSR_INDEX_BITS-1:0] index;
   logic [gsev_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[src/gsev_unit.sv]
// Shared compare unit: deadzone test of a stick axis or threshold test of a trigger,
// plus the change test against the kept value. Depends on gsev_pkg.
module gsev_unit (
   input  gsev_pkg::unit_in_type  unit_in,
   output gsev_pkg::unit_out_type unit_out
);

   logic [gsev_pkg::AXIS_BITS-1:0] mag;

   always_comb begin
      if (unit_in.is_axis && unit_in.operand[gsev_pkg::AXIS_BITS-1]) begin
         mag = (~unit_in.operand) + {{(gsev_pkg::AXIS_BITS-1){1'b0}}, 1'b1};
      end else begin
         mag = unit_in.operand;
      end
      unit_out.pass = (mag >= unit_in.limit);
      if (unit_in.is_axis && !unit_out.pass) begin
         unit_out.value = '0;
      end else begin
         unit_out.value = unit_in.operand;
      end
      unit_out.differs = (unit_out.value != unit_in.prior);
   end

endmodule

[src/gsev_seq.sv]
// Sequencer of the gamepad event generator: kept pad state, the step sequence over the
// shared compare unit, the button scan and the output register. Depends on gsev_pkg,
// gsev_if, gsev_unit and the assertion macro header.
`include "gamepad_sample_event_generator_defines.svh"

module gsev_seq (
   input  logic              clock,
   input  logic              reset,
   input  gsev_pkg::cfg_type cfg,
   gsev_req_if.sink          req,
   gsev_rsp_if.source        rsp
);

   localparam int AB = gsev_pkg::AXIS_BITS;
   localparam int TB = gsev_pkg::TRIG_BITS;
   localparam int BB = gsev_pkg::BUTTON_BITS;
   localparam int IB = gsev_pkg::INDEX_BITS;

   gsev_pkg::state_type    state_ff, state_in;
   logic [1:0]             step_ff, step_in;
   logic [IB-1:0]          idx_ff, idx_in;
   logic                   moved_ff, moved_in;
   logic [BB-1:0]          pad_ff, pad_in;
   logic [BB-1:0]          rem_ff, rem_in;
   logic [BB-1:0]          held_ff, held_in;
   logic [AB-1:0]          axis_ff [4];
   logic [AB-1:0]          axis_in [4];
   logic [AB-1:0]          dead_ff [4];
   logic [AB-1:0]          dead_in [4];
   logic [AB-1:0]          last_axis_ff [4];
   logic [AB-1:0]          last_axis_in [4];
   logic [TB-1:0]          trig_ff [2];
   logic [TB-1:0]          trig_in [2];
   logic [TB-1:0]          last_trig_ff [2];
   logic [TB-1:0]          last_trig_in [2];
   logic                   out_valid_ff, out_valid_in;
   gsev_pkg::rsp_word_type out_word_ff, out_word_in;

   gsev_pkg::unit_in_type  unit_in;
   gsev_pkg::unit_out_type unit_out;
   logic                   out_free;
   logic [BB-1:0]          changed;
   logic [BB-1:0]          rem_next;

   gsev_unit u_unit (
      .unit_in  (unit_in),
      .unit_out (unit_out)
   );

   assign out_free = !out_valid_ff || rsp.ready;
   assign changed  = held_ff ^ pad_ff;
   assign req.ready = (state_ff == gsev_pkg::S_IDLE);

   always_comb begin
      if (state_ff == gsev_pkg::S_TRIG) begin
         unit_in.is_axis = 1'b0;
         unit_in.operand = {{(AB-TB){1'b0}}, trig_ff[step_ff[0]]};
         unit_in.limit   = {{(AB-TB){1'b0}}, cfg.trigger_threshold};
         unit_in.prior   = {{(AB-TB){1'b0}}, last_trig_ff[step_ff[0]]};
      end else begin
         unit_in.is_axis = 1'b1;
         unit_in.operand = axis_ff[step_ff];
         unit_in.limit   = step_ff[1] ? cfg.right_deadzone : cfg.left_deadzone;
         unit_in.prior   = last_axis_ff[step_ff];
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      moved_in     = moved_ff;
      pad_in       = pad_ff;
      rem_in       = rem_ff;
      held_in      = held_ff;
      axis_in      = axis_ff;
      dead_in      = dead_ff;
      last_axis_in = last_axis_ff;
      trig_in      = trig_ff;
      last_trig_in = last_trig_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_word_in  = out_word_ff;
      rem_next     = rem_ff;
      rem_next[idx_ff] = 1'b0;

      unique case (state_ff)
         gsev_pkg::S_IDLE: begin
            if (req.valid) begin
               if (!cfg.enabled || !req.connected) begin
                  held_in      = '0;
                  last_axis_in = '{default: '0};
                  last_trig_in = '{default: '0};
               end else begin
                  pad_in     = gsev_pkg::remap_buttons(req.raw_buttons);
                  axis_in[0] = req.left_x;
                  axis_in[1] = req.left_y;
                  axis_in[2] = req.right_x;
                  axis_in[3] = req.right_y;
                  trig_in[0] = req.left_trigger;
                  trig_in[1] = req.right_trigger;
                  moved_in   = 1'b0;
                  step_in    = '0;
                  state_in   = gsev_pkg::S_AXIS;
               end
            end
         end
         gsev_pkg::S_AXIS: begin
            dead_in[step_ff] = unit_out.value;
            moved_in = moved_ff || unit_out.differs;
            step_in  = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = gsev_pkg::S_TRIG;
            end
         end
         gsev_pkg::S_TRIG: begin
            moved_in = moved_ff || unit_out.differs;
            if (step_ff[0]) begin
               if (unit_out.pass) begin
                  pad_in[gsev_pkg::PAD_RT_BIT] = 1'b1;
               end
               step_in  = '0;
               state_in = gsev_pkg::S_MOVE;
            end else begin
               if (unit_out.pass) begin
                  pad_in[gsev_pkg::PAD_LT_BIT] = 1'b1;
               end
               step_in = step_ff + 2'd1;
            end
         end
         gsev_pkg::S_MOVE: begin
            if (!moved_ff || out_free) begin
               if (moved_ff) begin
                  out_valid_in                  = 1'b1;
                  out_word_in.event_kind        = gsev_pkg::EV_MOVE;
                  out_word_in.slot              = cfg.pad_number;
                  out_word_in.button_index      = '0;
                  out_word_in.button_down       = 1'b0;
                  out_word_in.out_left_x        = dead_ff[0];
                  out_word_in.out_left_y        = dead_ff[1];
                  out_word_in.out_right_x       = dead_ff[2];
                  out_word_in.out_right_y       = dead_ff[3];
                  out_word_in.out_left_trigger  = trig_ff[0];
                  out_word_in.out_right_trigger = trig_ff[1];
                  out_word_in.last              = (changed == '0);
               end
               rem_in       = changed;
               idx_in       = '0;
               held_in      = pad_ff;
               last_axis_in = dead_ff;
               last_trig_in = trig_ff;
               state_in     = gsev_pkg::S_SCAN;
            end
         end
         gsev_pkg::S_SCAN: begin
            if (rem_ff == '0) begin
               state_in = gsev_pkg::S_IDLE;
            end else if (rem_ff[idx_ff]) begin
               if (out_free) begin
                  out_valid_in                  = 1'b1;
                  out_word_in.event_kind        = gsev_pkg::EV_BUTTON;
                  out_word_in.slot              = cfg.pad_number;
                  out_word_in.button_index      = idx_ff;
                  out_word_in.button_down       = pad_ff[idx_ff];
                  out_word_in.out_left_x        = '0;
                  out_word_in.out_left_y        = '0;
                  out_word_in.out_right_x       = '0;
                  out_word_in.out_right_y       = '0;
                  out_word_in.out_left_trigger  = '0;
                  out_word_in.out_right_trigger = '0;
                  out_word_in.last              = (rem_next == '0);
                  rem_in = rem_next;
                  idx_in = idx_ff + {{(IB-1){1'b0}}, 1'b1};
               end
            end else begin
               idx_in = idx_ff + {{(IB-1){1'b0}}, 1'b1};
            end
         end
         default: begin
            state_in = gsev_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsev_pkg::S_IDLE;
         step_ff      <= '0;
         idx_ff       <= '0;
         moved_ff     <= 1'b0;
         rem_ff       <= '0;
         pad_ff       <= '0;
         held_ff      <= '0;
         last_axis_ff <= '{default: '0};
         last_trig_ff <= '{default: '0};
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         moved_ff     <= moved_in;
         rem_ff       <= rem_in;
         pad_ff       <= pad_in;
         held_ff      <= held_in;
         last_axis_ff <= last_axis_in;
         last_trig_ff <= last_trig_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff     <= axis_in;
      dead_ff     <= dead_in;
      trig_ff     <= trig_in;
      out_word_ff <= out_word_in;
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.event_kind        = out_word_ff.event_kind;
   assign rsp.slot              = out_word_ff.slot;
   assign rsp.button_index      = out_word_ff.button_index;
   assign rsp.button_down       = out_word_ff.button_down;
   assign rsp.out_left_x        = out_word_ff.out_left_x;
   assign rsp.out_left_y        = out_word_ff.out_left_y;
   assign rsp.out_right_x       = out_word_ff.out_right_x;
   assign rsp.out_right_y       = out_word_ff.out_right_y;
   assign rsp.out_left_trigger  = out_word_ff.out_left_trigger;
   assign rsp.out_right_trigger = out_word_ff.out_right_trigger;
   assign rsp.last              = out_word_ff.last;

   `GSEV_ASSERT_NXT(a_scan_end, clock, reset, (state_ff == gsev_pkg::S_SCAN) && (rem_ff == '0), state_ff == gsev_pkg::S_IDLE)
   `GSEV_ASSERT_IMP(a_scan_committed, clock, reset, state_ff == gsev_pkg::S_SCAN, held_ff == pad_ff)
   `GSEV_ASSERT_IMP(a_button_word_clean, clock, reset, out_valid_ff && (out_word_ff.event_kind == gsev_pkg::EV_BUTTON), (out_word_ff.out_left_x == '0) && (out_word_ff.out_left_y == '0) && (out_word_ff.out_right_x == '0) && (out_word_ff.out_right_y == '0) && (out_word_ff.out_left_trigger == '0) && (out_word_ff.out_right_trigger == '0))
   `GSEV_ASSERT_NXT(a_start_steps, clock, reset, req.valid && req.ready && cfg.enabled && req.connected, state_ff == gsev_pkg::S_AXIS)

endmodule

[src/gamepad_sample_event_generator.sv]
// Top level of the gamepad sample event generator: register file and sequencer.
// Depends on gsev_pkg, gsev_if and gsev_seq.
//
// One poll sample is taken per req word. A sample that arrives while the slot is disabled
// or the pad is disconnected clears the kept pad state and yields no word. Otherwise a
// single compare unit is stepped over the four stick axes and the two triggers, then the
// move word is issued if anything moved, and the pad bits are scanned one per cycle up to
// the highest changed bit, one button word for each changed bit. The move word and each
// button word wait while the output register holds a word that rsp has not taken. req is
// ready only between samples; a finished word waits in the output register while the next
// sample is taken. csr is always ready, and registers are to be written only while no
// sample is in flight.
module gamepad_sample_event_generator (
   input  logic       clock,
   input  logic       reset,
   gsev_req_if.sink   req_bus,
   gsev_rsp_if.source rsp_bus,
   gsev_csr_if.sink   csr_bus
);

   logic                              enabled_ff;
   logic [1:0]                        pad_number_ff;
   logic [gsev_pkg::AXIS_BITS-1:0]    left_dz_ff;
   logic [gsev_pkg::AXIS_BITS-1:0]    right_dz_ff;
   logic [gsev_pkg::TRIG_BITS-1:0]    trig_thr_ff;
   gsev_pkg::cfg_type                 cfg;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= gsev_pkg::CSR_ENABLED_RESET[0];
         pad_number_ff <= gsev_pkg::CSR_PAD_RESET;
         left_dz_ff    <= gsev_pkg::CSR_LEFT_DZ_RESET;
         right_dz_ff   <= gsev_pkg::CSR_RIGHT_DZ_RESET;
         trig_thr_ff   <= gsev_pkg::CSR_TRIG_THR_RESET;
      end else if (csr_bus.valid) begin
         unique case (gsev_pkg::csr_index_type'(csr_bus.index))
            gsev_pkg::CSR_ENABLED:  enabled_ff    <= csr_bus.data[0];
            gsev_pkg::CSR_PAD:      pad_number_ff <= csr_bus.data[1:0];
            gsev_pkg::CSR_LEFT_DZ:  left_dz_ff    <= csr_bus.data;
            gsev_pkg::CSR_RIGHT_DZ: right_dz_ff   <= csr_bus.data;
            gsev_pkg::CSR_TRIG_THR: trig_thr_ff   <= csr_bus.data[gsev_pkg::TRIG_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.enabled           = enabled_ff;
   assign cfg.pad_number        = pad_number_ff;
   assign cfg.left_deadzone     = left_dz_ff;
   assign cfg.right_deadzone    = right_dz_ff;
   assign cfg.trigger_threshold = trig_thr_ff;

   gsev_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

endmodule
